FILE: design/rwpm_pkg.sv
`timescale 1ns / 1ps
package rwpm_pkg;

  localparam int unsigned TableEntries = 64;

  localparam logic [1:0] OP_JOIN   = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_MATCH  = 2'd2;

  localparam logic [2:0] ST_JOINED    = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_MATCHED   = 3'd5;
  localparam logic [2:0] ST_NO_MATCH  = 3'd6;

  localparam logic [1:0] REG_INITIAL_RANGE = 2'd0;
  localparam logic [1:0] REG_GROWTH        = 2'd1;
  localparam logic [1:0] REG_MAX_RANGE     = 2'd2;

  localparam logic [15:0] INITIAL_RANGE_RST = 16'd100;
  localparam logic [15:0] GROWTH_RST        = 16'd20;
  localparam logic [15:0] MAX_RANGE_RST     = 16'd500;

  typedef struct packed {
    logic [31:0] user;
    logic [15:0] rating;
    logic [31:0] joined;
  } entry_t;

  typedef struct packed {
    logic [15:0] initial_range;
    logic [15:0] growth;
    logic [15:0] max_range;
  } win_cfg_t;

  function automatic logic rating_before(entry_t a, entry_t b);
    rating_before = (a.rating < b.rating) || ((a.rating == b.rating) && (a.user < b.user));
  endfunction

  function automatic logic age_before(entry_t a, entry_t b);
    age_before = (a.joined < b.joined) || ((a.joined == b.joined) && (a.user < b.user));
  endfunction

endpackage

FILE: design/rating_window_pair_matcher_core.sv
`timescale 1ns / 1ps
// Join and cancel: one pass over the entry memory read port.
// Try match: each valid candidate entry older than the current first pick takes a full
// neighbor scan over the entry memory read port, then one window check.
// One request at a time; the result register frees the input side once loaded.
// Reset clears all valid bits at once and loads the default window registers; no sweep.
module rating_window_pair_matcher_core #(
  parameter int unsigned TABLE_ENTRIES = rwpm_pkg::TableEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] user_id_i,
  input  logic [15:0] rating_i,
  input  logic [31:0] join_time_i,
  input  logic [31:0] current_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] first_user_o,
  output logic [15:0] first_rating_o,
  output logic [31:0] first_join_time_o,
  output logic [31:0] second_user_o,
  output logic [15:0] second_rating_o,
  output logic [31:0] second_join_time_o
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] LAST_M1 = CW'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_TMO  = 3'd2;
  localparam logic [2:0] S_TMW  = 3'd3;
  localparam logic [2:0] S_TMI  = 3'd4;
  localparam logic [2:0] S_TME  = 3'd5;
  localparam logic [2:0] S_TMX  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_q, state_d;
  rwpm_pkg::win_cfg_t cfg_q;

  logic [1:0]  op_q, op_d;
  logic [31:0] id_q, id_d;
  logic [15:0] rat_q, rat_d;
  logic [31:0] jt_q, jt_d;
  logic [31:0] now_q, now_d;

  logic [CW-1:0] cnt_q, cnt_d, oi_q, oi_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] pidx_q, pidx_d;
  logic          hit_q, hit_d, free_q, free_d;
  logic [IW-1:0] hidx_q, hidx_d, fidx_q, fidx_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;

  rwpm_pkg::entry_t cur_q, cur_d, prev_q, prev_d, next_q, next_d;
  rwpm_pkg::entry_t first_q, first_d, second_q, second_d;
  logic          prev_f_q, prev_f_d, next_f_q, next_f_d, first_f_q, first_f_d;
  logic [IW-1:0] pvi_q, pvi_d, nvi_q, nvi_d, fi_q, fi_d, si_q, si_d;
  logic [2:0]    st_q, st_d;

  logic        out_valid_q;
  logic [2:0]  r_status_q;
  rwpm_pkg::entry_t r_first_q, r_second_q;

  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  rwpm_pkg::entry_t mem_wdata, rdata;
  logic          win_load, qual_p, qual_n;
  logic [15:0]   diff_p, diff_n;
  logic          take_n;
  logic          fin_go;

  rwpm_store #(.ENTRIES(TABLE_ENTRIES)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  assign diff_p = cur_q.rating - prev_q.rating;
  assign diff_n = next_q.rating - cur_q.rating;

  rwpm_window u_window (
    .clk_i    (clk_i),
    .load_i   (win_load),
    .joined_i (rdata.joined),
    .now_i    (now_q),
    .cfg_i    (cfg_q),
    .diff_p_i (diff_p),
    .diff_n_i (diff_n),
    .qual_p_o (qual_p),
    .qual_n_o (qual_n)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign fin_go = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    op_d = op_q; id_d = id_q; rat_d = rat_q; jt_d = jt_q; now_d = now_q;
    cnt_d = cnt_q; oi_d = oi_q; pend_d = 1'b0; pidx_d = pidx_q;
    hit_d = hit_q; hidx_d = hidx_q; free_d = free_q; fidx_d = fidx_q;
    valid_d = valid_q;
    cur_d = cur_q; prev_d = prev_q; next_d = next_q;
    first_d = first_q; second_d = second_q;
    prev_f_d = prev_f_q; next_f_d = next_f_q; first_f_d = first_f_q;
    pvi_d = pvi_q; nvi_d = nvi_q; fi_d = fi_q; si_d = si_q;
    st_d = st_q;
    mem_we = 1'b0;
    mem_waddr = fidx_q;
    mem_wdata = '{user: id_q, rating: rat_q, joined: jt_q};
    mem_raddr = cnt_q[IW-1:0];
    win_load = 1'b0;
    take_n = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = operation_i; id_d = user_id_i; rat_d = rating_i;
          jt_d = join_time_i; now_d = current_time_i;
          cnt_d = '0; oi_d = '0;
          hit_d = 1'b0; free_d = 1'b0; first_f_d = 1'b0;
          case (operation_i)
            rwpm_pkg::OP_JOIN, rwpm_pkg::OP_CANCEL: state_d = S_SCAN;
            rwpm_pkg::OP_MATCH: state_d = S_TMO;
            default: begin
              st_d = rwpm_pkg::ST_NO_MATCH;
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (cnt_q != LAST) begin
          pend_d = 1'b1;
          pidx_d = cnt_q[IW-1:0];
          cnt_d = cnt_q + 1'b1;
        end
        if (pend_q) begin
          if (valid_q[pidx_q] && (rdata.user == id_q) && !hit_q) begin
            hit_d = 1'b1; hidx_d = pidx_q;
          end
          if (!valid_q[pidx_q] && !free_q) begin
            free_d = 1'b1; fidx_d = pidx_q;
          end
        end
        if ((cnt_q == LAST) && !pend_q) begin
          state_d = S_FIN;
          if (op_q == rwpm_pkg::OP_JOIN) begin
            if (hit_q) begin
              st_d = rwpm_pkg::ST_DUPLICATE;
            end else if (free_q) begin
              mem_we = 1'b1;
              valid_d[fidx_q] = 1'b1;
              st_d = rwpm_pkg::ST_JOINED;
            end else begin
              st_d = rwpm_pkg::ST_FULL;
            end
          end else begin
            if (hit_q) begin
              valid_d[hidx_q] = 1'b0;
              st_d = rwpm_pkg::ST_CANCELLED;
            end else begin
              st_d = rwpm_pkg::ST_NOT_FOUND;
            end
          end
        end
      end

      S_TMO: begin
        mem_raddr = oi_q[IW-1:0];
        state_d = S_TMW;
      end

      S_TMW: begin
        cur_d = rdata;
        if (!valid_q[oi_q[IW-1:0]] ||
            (first_f_q && !rwpm_pkg::age_before(rdata, first_q))) begin
          oi_d = oi_q + 1'b1;
          state_d = (oi_q == LAST_M1) ? S_TMX : S_TMO;
        end else begin
          win_load = 1'b1;
          cnt_d = '0;
          prev_f_d = 1'b0;
          next_f_d = 1'b0;
          state_d = S_TMI;
        end
      end

      S_TMI: begin
        if (cnt_q != LAST) begin
          pend_d = 1'b1;
          pidx_d = cnt_q[IW-1:0];
          cnt_d = cnt_q + 1'b1;
        end
        if (pend_q && valid_q[pidx_q] && (pidx_q != oi_q[IW-1:0])) begin
          if (rwpm_pkg::rating_before(rdata, cur_q)) begin
            if (!prev_f_q || rwpm_pkg::rating_before(prev_q, rdata)) begin
              prev_f_d = 1'b1; prev_d = rdata; pvi_d = pidx_q;
            end
          end else begin
            if (!next_f_q || rwpm_pkg::rating_before(rdata, next_q)) begin
              next_f_d = 1'b1; next_d = rdata; nvi_d = pidx_q;
            end
          end
        end
        if ((cnt_q == LAST) && !pend_q) begin
          state_d = S_TME;
        end
      end

      S_TME: begin
        // closer neighbor wins, smaller id on a tie
        if (next_f_q && qual_n) begin
          take_n = !(prev_f_q && qual_p) || (diff_n < diff_p) ||
                   ((diff_n == diff_p) && (next_q.user < prev_q.user));
        end
        if ((prev_f_q && qual_p) || take_n) begin
          first_f_d = 1'b1;
          first_d = cur_q;
          fi_d = oi_q[IW-1:0];
          second_d = take_n ? next_q : prev_q;
          si_d = take_n ? nvi_q : pvi_q;
        end
        oi_d = oi_q + 1'b1;
        state_d = (oi_q == LAST_M1) ? S_TMX : S_TMO;
      end

      S_TMX: begin
        if (first_f_q) begin
          valid_d[fi_q] = 1'b0;
          valid_d[si_q] = 1'b0;
          st_d = rwpm_pkg::ST_MATCHED;
        end else begin
          st_d = rwpm_pkg::ST_NO_MATCH;
        end
        state_d = S_FIN;
      end

      S_FIN: begin
        if (fin_go) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q <= '{initial_range: rwpm_pkg::INITIAL_RANGE_RST,
                 growth: rwpm_pkg::GROWTH_RST,
                 max_range: rwpm_pkg::MAX_RANGE_RST};
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      pend_q <= pend_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          rwpm_pkg::REG_INITIAL_RANGE: cfg_q.initial_range <= cfg_wdata_i;
          rwpm_pkg::REG_GROWTH:        cfg_q.growth <= cfg_wdata_i;
          rwpm_pkg::REG_MAX_RANGE:     cfg_q.max_range <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; id_q <= id_d; rat_q <= rat_d; jt_q <= jt_d; now_q <= now_d;
    cnt_q <= cnt_d; oi_q <= oi_d; pidx_q <= pidx_d;
    hit_q <= hit_d; hidx_q <= hidx_d; free_q <= free_d; fidx_q <= fidx_d;
    cur_q <= cur_d; prev_q <= prev_d; next_q <= next_d;
    first_q <= first_d; second_q <= second_d;
    prev_f_q <= prev_f_d; next_f_q <= next_f_d; first_f_q <= first_f_d;
    pvi_q <= pvi_d; nvi_q <= nvi_d; fi_q <= fi_d; si_q <= si_d;
    st_q <= st_d;
    if (fin_go) begin
      r_status_q <= st_q;
      if (st_q == rwpm_pkg::ST_MATCHED) begin
        r_first_q <= first_q;
        r_second_q <= second_q;
      end else begin
        r_first_q <= '0;
        r_second_q <= '0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = r_status_q;
  assign first_user_o       = r_first_q.user;
  assign first_rating_o     = r_first_q.rating;
  assign first_join_time_o  = r_first_q.joined;
  assign second_user_o      = r_second_q.user;
  assign second_rating_o    = r_second_q.rating;
  assign second_join_time_o = r_second_q.joined;

endmodule

FILE: design/rwpm_store.sv
`timescale 1ns / 1ps
module rwpm_store #(
  parameter int unsigned ENTRIES = rwpm_pkg::TableEntries,
  localparam int unsigned IW = $clog2(ENTRIES)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IW-1:0]    waddr_i,
  input  rwpm_pkg::entry_t wdata_i,
  input  logic [IW-1:0]    raddr_i,
  output rwpm_pkg::entry_t rdata_o
);

  rwpm_pkg::entry_t mem [ENTRIES];
  rwpm_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/rwpm_window.sv
`timescale 1ns / 1ps
module rwpm_window (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic [31:0]        joined_i,
  input  logic [31:0]        now_i,
  input  rwpm_pkg::win_cfg_t cfg_i,
  input  logic [15:0]        diff_p_i,
  input  logic [15:0]        diff_n_i,
  output logic               qual_p_o,
  output logic               qual_n_o
);

  logic        zero_q;
  logic [47:0] prod_q;
  logic [31:0] elapsed;
  logic [48:0] limit;

  assign elapsed = now_i - joined_i;

  // elapsed * growth is registered once per candidate entry that is scanned for neighbors
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      zero_q <= (now_i <= joined_i);
      prod_q <= elapsed * cfg_i.growth;
    end
  end

  assign limit = ({33'd0, cfg_i.initial_range} * 49'd1000) + {1'b0, prod_q};

  function automatic logic qual(logic [15:0] d, logic z, logic [48:0] lim,
                                rwpm_pkg::win_cfg_t c);
    logic [48:0] scaled;
    scaled = {33'd0, d} * 49'd1000;
    if (z) begin
      qual = (d <= c.initial_range);
    end else begin
      qual = (d <= c.max_range) && (scaled <= lim);
    end
  endfunction

  assign qual_p_o = qual(diff_p_i, zero_q, limit, cfg_i);
  assign qual_n_o = qual(diff_n_i, zero_q, limit, cfg_i);

endmodule
